/* rtl/raw_pkg.sv */
// Shared types, codes and sizes for the reliable ack window block.
package raw_pkg;

    // Ring geometry
    localparam int WINDOW = 32;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Field widths
    localparam int SEQ_W    = 32;
    localparam int TIME_W   = 32;
    localparam int MASK_W   = 32;
    localparam int LEN_W    = 16;
    localparam int RSND_W   = 8;
    localparam int IVL_W    = 16;
    localparam int IN_W     = TIME_W + SEQ_W + MASK_W + LEN_W;
    localparam int OUT_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESENDS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD     = 2'd2;

    // Configuration reset values
    localparam logic [IVL_W-1:0]  RST_RESEND_INTERVAL = 16'd100;
    localparam logic [RSND_W-1:0] RST_MAX_RESENDS     = 8'd20;
    localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD     = 16'd1184;

    localparam logic [RSND_W-1:0] RSND_SAT = '1;

    typedef enum logic [1:0] {
        KIND_SEND = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_CONN = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RK_SENT   = 3'd0,
        RK_RESEND = 3'd1,
        RK_STATUS = 3'd2,
        RK_NOCONN = 3'd3,
        RK_FULL   = 3'd4,
        RK_LONG   = 3'd5
    } t_rkind;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] sent_time;
        logic [RSND_W-1:0] resends;
    } t_entry;

    typedef struct packed {
        logic latch;
        logic scan_start;
        logic rd;
        logic ack_eval;
        logic tick_eval;
        logic pop;
        logic send;
        logic connect;
        logic status;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  link;
        logic  scan_end;
        logic  pop_ok;
        logic  due;
        logic  out_free;
    } t_dp_status;

endpackage

/* rtl/reliable_ack_window.sv */
// Top level of the reliable ack window: sender-side retransmit bookkeeping.
//
// Input channel (s_axis): one item per event. tuser carries the kind (send,
// ack, tick, connect); tdata carries now_ms, ack_sequence, ack_mask and the
// payload length. Output channel (m_axis): result items, tuser the result kind,
// tlast set on the final result of an item.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data write resend interval,
// max resends and max payload length; write only while the block is idle.
//
// One item is handled at a time. A send is latched, dispatched and
// written to the result register once that is free; a connect passes
// through the dispatch, connect and status states. An ack walks the pending
// ring with a registered memory read, then a compare, for each entry, then
// pops acked head entries one per cycle. While the link is up a tick
// walks the ring the same way, each entry through the single read port.
// The next item is taken as soon as the last result sits in the output
// register, so a waiting result does not block acceptance.
// Reset: the link is down, the ring empty, registers at their defaults.
// A stalled receiver holds the result register; the walk pauses on the
// next resend until the register frees, and no result is lost.
module reliable_ack_window import raw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_W-1:0]      i_s_axis_tdata,  // now_ms, ack_sequence, ack_mask, pay_len
    input  logic [1:0]           i_s_axis_tuser,  // kind
    // result items
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,  // sequence_out, slot_out, pending_out, link_up
    output logic [2:0]           o_m_axis_tuser,  // result_kind
    output logic                 o_m_axis_tlast   // last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    raw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    raw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item_kind (i_s_axis_tuser),
        .i_item_data (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

/* rtl/raw_dp.sv */
// Datapath: config registers, ring state, entry memory and result register.
module raw_dp import raw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [1:0]           i_item_kind,
    input  logic [IN_W-1:0]      i_item_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_out_kind,
    output logic [OUT_W-1:0]     o_out_data,
    output logic                 o_out_last
);

    logic [IVL_W-1:0]  r_interval;
    logic [RSND_W-1:0] r_max_resends;
    logic [LEN_W-1:0]  r_max_len;

    logic              r_link;
    logic [SEQ_W-1:0]  r_next_seq;
    logic [SLOT_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [WINDOW-1:0] r_acked;

    t_entry            r_mem [WINDOW];
    t_entry            r_rd_entry;
    logic [SLOT_W-1:0] r_rd_slot;

    t_kind             r_kind;
    logic [TIME_W-1:0] r_now;
    logic [SEQ_W-1:0]  r_ack;
    logic [MASK_W-1:0] r_mask;
    logic [LEN_W-1:0]  r_len;

    logic              r_out_valid;
    t_rkind            r_out_kind;
    logic [SEQ_W-1:0]  r_out_seq;
    logic [SLOT_W-1:0] r_out_slot;
    logic [CNT_W-1:0]  r_out_pending;
    logic              r_out_link;
    logic              r_out_last;

    logic [SLOT_W-1:0] send_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic              too_long;
    logic              full;
    logic              send_ok;
    logic [TIME_W-1:0] age;
    logic              due;
    logic              tick_hit;
    logic              drop;
    logic [SEQ_W-1:0]  seq_gap;
    logic [SEQ_W-1:0]  gap_m1;
    logic              ack_hit;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_addr;
    t_entry            mem_wdata;
    logic              out_free;
    logic              out_load;
    t_rkind            send_kind;

    assign send_slot = r_head + r_count[SLOT_W-1:0];
    assign rd_addr   = r_head + r_idx[SLOT_W-1:0];
    assign too_long  = r_len > r_max_len;
    assign full      = r_count >= CNT_W'(WINDOW);
    assign send_ok   = i_cmd.send && r_link && !too_long && !full;

    // Age check for a resend, modulo 2^32
    assign age      = r_now - r_rd_entry.sent_time;
    assign due      = !r_acked[r_rd_slot] && (age >= TIME_W'(r_interval));
    assign tick_hit = i_cmd.tick_eval && due;
    assign drop     = r_rd_entry.resends >= r_max_resends;

    // Ack match: the newest sequence itself, or one of the 32 before it
    assign seq_gap = r_ack - r_rd_entry.seq;
    assign gap_m1  = seq_gap - SEQ_W'(1);
    assign ack_hit = (seq_gap == '0) ||
                     ((gap_m1 < SEQ_W'(MASK_W)) && r_mask[gap_m1[$clog2(MASK_W)-1:0]]);

    assign mem_we   = send_ok || tick_hit;
    assign mem_addr = send_ok ? send_slot : r_rd_slot;
    always_comb begin
        if (send_ok) begin
            mem_wdata.seq       = r_next_seq;
            mem_wdata.sent_time = r_now;
            mem_wdata.resends   = '0;
        end else begin
            mem_wdata.seq       = r_rd_entry.seq;
            mem_wdata.sent_time = r_now;
            mem_wdata.resends   = (r_rd_entry.resends == RSND_SAT) ? RSND_SAT :
                                  r_rd_entry.resends + RSND_W'(1);
        end
    end

    always_comb begin
        if (!r_link)       send_kind = RK_NOCONN;
        else if (too_long) send_kind = RK_LONG;
        else if (full)     send_kind = RK_FULL;
        else               send_kind = RK_SENT;
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = i_cmd.send || tick_hit || i_cmd.status;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_entry <= r_mem[rd_addr];
            r_rd_slot  <= rd_addr;
        end
    end

    // Acked flags, latched item and result fields: no reset needed
    always_ff @(posedge i_clk) begin
        if (send_ok) begin
            r_acked[send_slot] <= 1'b0;
        end
        if (i_cmd.ack_eval && ack_hit) begin
            r_acked[r_rd_slot] <= 1'b1;
        end
        if (i_cmd.latch) begin
            r_kind <= t_kind'(i_item_kind);
            r_now  <= i_item_data[TIME_W-1:0];
            r_ack  <= i_item_data[TIME_W +: SEQ_W];
            r_mask <= i_item_data[TIME_W+SEQ_W +: MASK_W];
            r_len  <= i_item_data[TIME_W+SEQ_W+MASK_W +: LEN_W];
        end
        if (out_load) begin
            r_out_last <= !tick_hit;
            if (i_cmd.send) begin
                r_out_kind    <= send_kind;
                r_out_seq     <= send_ok ? r_next_seq : '0;
                r_out_slot    <= send_ok ? send_slot : '0;
                r_out_pending <= send_ok ? r_count + CNT_W'(1) : r_count;
                r_out_link    <= r_link;
            end else if (tick_hit) begin
                r_out_kind    <= RK_RESEND;
                r_out_seq     <= r_rd_entry.seq;
                r_out_slot    <= r_rd_slot;
                r_out_pending <= r_count;
                r_out_link    <= r_link && !drop;
            end else begin
                r_out_kind    <= RK_STATUS;
                r_out_seq     <= '0;
                r_out_slot    <= '0;
                r_out_pending <= r_count;
                r_out_link    <= r_link;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= RST_RESEND_INTERVAL;
            r_max_resends <= RST_MAX_RESENDS;
            r_max_len     <= RST_MAX_PAYLOAD;
            r_link        <= 1'b0;
            r_next_seq    <= '0;
            r_head        <= '0;
            r_count       <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RESEND_INTERVAL: r_interval    <= i_cfg_data[IVL_W-1:0];
                    CFG_MAX_RESENDS:     r_max_resends <= i_cfg_data[RSND_W-1:0];
                    CFG_MAX_PAYLOAD:     r_max_len     <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.connect) begin
                r_link     <= 1'b1;
                r_next_seq <= '0;
            end else begin
                if (tick_hit && drop) r_link <= 1'b0;
                if (send_ok)          r_next_seq <= r_next_seq + SEQ_W'(1);
            end
            if (send_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.pop) begin
                r_head <= r_head + SLOT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.ack_eval || i_cmd.tick_eval) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.link     = r_link;
    assign o_status.scan_end = (r_idx == r_count);
    assign o_status.pop_ok   = (r_count != '0) && r_acked[r_head];
    assign o_status.due      = due;
    assign o_status.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {{(OUT_W-SEQ_W-SLOT_W-CNT_W-1){1'b0}},
                          r_out_link, r_out_pending, r_out_slot, r_out_seq};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW))
        else $error("pending count above window");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from empty ring");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

    a_send_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        send_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted send did not grow the ring");

endmodule

/* rtl/raw_ctrl.sv */
// Controller: sequences send, ack walk, pop, tick walk and status results.
module raw_ctrl import raw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEND,
        ST_CONN,
        ST_ACK_RD,
        ST_ACK_EV,
        ST_POP,
        ST_TICK_RD,
        ST_TICK_EV,
        ST_STATUS
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_status.kind)
                    KIND_SEND: n_state = ST_SEND;
                    KIND_ACK: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_ACK_RD;
                    end
                    KIND_TICK: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = i_status.link ? ST_TICK_RD : ST_STATUS;
                    end
                    default: n_state = ST_CONN;
                endcase
            end
            ST_SEND: begin
                if (i_status.out_free) begin
                    o_cmd.send = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_CONN: begin
                o_cmd.connect = 1'b1;
                n_state       = ST_STATUS;
            end
            ST_ACK_RD: begin
                if (i_status.scan_end) begin
                    n_state = ST_POP;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_ACK_EV;
                end
            end
            ST_ACK_EV: begin
                o_cmd.ack_eval = 1'b1;
                n_state        = ST_ACK_RD;
            end
            ST_POP: begin
                if (i_status.pop_ok) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    n_state = ST_STATUS;
                end
            end
            ST_TICK_RD: begin
                if (i_status.scan_end) begin
                    n_state = ST_STATUS;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_TICK_EV;
                end
            end
            ST_TICK_EV: begin
                // hold while a resend waits for the result register
                if (!i_status.due || i_status.out_free) begin
                    o_cmd.tick_eval = 1'b1;
                    n_state         = ST_TICK_RD;
                end
            end
            ST_STATUS: begin
                if (i_status.out_free) begin
                    o_cmd.status = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the reliable ack window: directed table, then random phases.
module tb;
    import raw_pkg::*;

    // Index past the three registers: the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Long receiver hold-off, long enough to stall the block's input
    localparam int RX_HOLD_CYCLES = 400;
    // Worst case is about 300 items x 33 results x a long receiver gap, taken
    // several times over
    localparam int TIMEOUT_NS = 20_000_000;

    typedef struct {
        t_kind             kind;
        logic [TIME_W-1:0] now_ms;
        logic [SEQ_W-1:0]  ack_seq;
        logic [MASK_W-1:0] ack_mask;
        logic [LEN_W-1:0]  pay_len;
    } t_event;

    typedef struct {
        t_rkind            rkind;
        logic [SEQ_W-1:0]  seq;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  pend;
        logic              link;
        logic              is_last;
    } t_result;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct {
        t_event  ev;
        bit      typed;
        t_result want;
    } t_row;

    // Clock, reset and block ports; every input is known from time zero
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata = '0;   // now_ms, ack_sequence, ack_mask, pay_len
    logic [1:0]       i_s_axis_tuser = '0;   // kind
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;        // sequence_out, slot_out, pending_out, link_up
    logic [2:0]       o_m_axis_tuser;        // result_kind
    logic             o_m_axis_tlast;

    // Window tracker: the testbench's own copy of the block state
    logic              w_link = 1'b0;
    logic [SEQ_W-1:0]  w_next = '0;
    logic [SLOT_W-1:0] w_head = '0;
    int unsigned       w_count = 0;
    logic [SEQ_W-1:0]  ent_seq   [WINDOW];
    logic [TIME_W-1:0] ent_time  [WINDOW];
    logic [RSND_W-1:0] ent_rsnd  [WINDOW];
    logic              ent_acked [WINDOW];

    // Register shadow copies
    logic [IVL_W-1:0]  cfg_interval = RST_RESEND_INTERVAL;
    logic [RSND_W-1:0] cfg_max_rsnd = RST_MAX_RESENDS;
    logic [LEN_W-1:0]  cfg_max_len  = RST_MAX_PAYLOAD;

    // Results the block still owes, oldest first
    t_result due_results [$];
    t_row    dir_rows [$];

    logic [TIME_W-1:0] t_now = '0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit rx_hold_req = 1'b0;
    int fail_count = 0;

    reliable_ack_window u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
        return $urandom_range(20, 40);
    endfunction

    // Queue one expected result; pending count and link state are taken as
    // they stand at this point of the walk
    task automatic post_result(input t_rkind rk, input logic [SEQ_W-1:0] seq,
                               input int unsigned slot, input logic fin);
        t_result r;
        r.rkind   = rk;
        r.seq     = seq;
        r.slot    = slot[SLOT_W-1:0];
        r.pend    = w_count[CNT_W-1:0];
        r.link    = w_link;
        r.is_last = fin;
        due_results.push_back(r);
    endtask

    // Apply one accepted item to the tracked window and queue its results
    task automatic advance_window(input t_event ev);
        int unsigned k;
        int unsigned idx;
        logic [SEQ_W-1:0] gap;
        logic [SEQ_W-1:0] back;
        case (ev.kind)
            KIND_SEND: begin
                // link first, then length, then room; a reject changes nothing
                if (!w_link) begin
                    post_result(RK_NOCONN, '0, 0, 1'b1);
                end else if (ev.pay_len > cfg_max_len) begin
                    post_result(RK_LONG, '0, 0, 1'b1);
                end else if (w_count >= WINDOW) begin
                    post_result(RK_FULL, '0, 0, 1'b1);
                end else begin
                    idx = (w_head + w_count) % WINDOW;
                    ent_seq[idx]   = w_next;
                    ent_time[idx]  = ev.now_ms;
                    ent_rsnd[idx]  = '0;
                    ent_acked[idx] = 1'b0;
                    w_next  = w_next + 1'b1;
                    w_count = w_count + 1;
                    post_result(RK_SENT, ent_seq[idx], idx, 1'b1);
                end
            end
            KIND_ACK: begin
                // mark pending entries hit by the ack or its mask, link up or not
                for (k = 0; k < w_count; k++) begin
                    idx = (w_head + k) % WINDOW;
                    if (!ent_acked[idx]) begin
                        gap  = ev.ack_seq - ent_seq[idx];
                        back = gap - 1'b1;
                        if (gap == '0)
                            ent_acked[idx] = 1'b1;
                        else if (back < 32 && ev.ack_mask[back[4:0]])
                            ent_acked[idx] = 1'b1;
                    end
                end
                // pop acked entries from the head only
                while (w_count > 0 && ent_acked[w_head]) begin
                    w_head  = w_head + 1'b1;
                    w_count = w_count - 1;
                end
                post_result(RK_STATUS, '0, 0, 1'b1);
            end
            KIND_TICK: begin
                if (w_link) begin
                    for (k = 0; k < w_count; k++) begin
                        idx = (w_head + k) % WINDOW;
                        gap = ev.now_ms - ent_time[idx];
                        if (!ent_acked[idx] && gap >= cfg_interval) begin
                            ent_time[idx] = ev.now_ms;
                            // drop the link but keep scanning the ring
                            if (ent_rsnd[idx] >= cfg_max_rsnd) w_link = 1'b0;
                            if (ent_rsnd[idx] != RSND_SAT) ent_rsnd[idx] = ent_rsnd[idx] + 1'b1;
                            post_result(RK_RESEND, ent_seq[idx], idx, 1'b0);
                        end
                    end
                end
                post_result(RK_STATUS, '0, 0, 1'b1);
            end
            KIND_CONN: begin
                // restart numbering; pending entries stay where they are
                w_link = 1'b1;
                w_next = '0;
                post_result(RK_STATUS, '0, 0, 1'b1);
            end
        endcase
    endtask

    // Write one register; called at a falling edge, returns at the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_RESEND_INTERVAL: cfg_interval = val;
            CFG_MAX_RESENDS:     cfg_max_rsnd = val[RSND_W-1:0];
            CFG_MAX_PAYLOAD:     cfg_max_len  = val;
            default: ;
        endcase
    endtask

    // Offer one item and hold it until accepted; typed rows replace the
    // tracker's single result with the one written in the table
    task automatic offer_item(input t_event ev, input bit typed, input t_result want);
        if (tx_idle_on && $urandom_range(0, 2) == 0)
            repeat (gap_len()) @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {ev.pay_len, ev.ack_mask, ev.ack_seq, ev.now_ms};
        i_s_axis_tuser  = ev.kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        advance_window(ev);
        if (typed) begin
            void'(due_results.pop_back());
            due_results.push_back(want);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Hold the sender until the block owes nothing, then let it settle
    task automatic drain_all();
        while (due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Random item that mostly follows a sane link life: connect, send,
    // ack recent sequences, tick forward; unused fields carry noise
    task automatic build_item(output t_event ev);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        ev.now_ms   = t_now + $urandom_range(0, 3);
        ev.ack_seq  = $urandom;
        ev.ack_mask = $urandom;
        ev.pay_len  = 16'($urandom);
        if ((!w_link && pick < 40) || pick < 4) begin
            ev.kind = KIND_CONN;
        end else if (pick < 50) begin
            ev.kind = KIND_SEND;
            if ($urandom_range(0, 9) != 0) ev.pay_len = 16'($urandom_range(0, cfg_max_len));
        end else if (pick < 75) begin
            ev.kind = KIND_ACK;
            if ($urandom_range(0, 7) != 0) ev.ack_seq = w_next - 1 - $urandom_range(0, 5);
            case ($urandom_range(0, 3))
                0: ;
                1: ev.ack_mask = '1;
                2: ev.ack_mask = '0;
                default: ev.ack_mask = 32'd1 << $urandom_range(0, 31);
            endcase
        end else begin
            ev.kind = KIND_TICK;
            // occasional large jump, so time wraps now and then
            if ($urandom_range(0, 11) == 0)
                ev.now_ms = t_now + $urandom;
            else
                ev.now_ms = t_now + $urandom_range(0, 2 * cfg_interval);
        end
        t_now = ev.now_ms;
    endtask

    task automatic run_random(input int count);
        t_event  ev;
        t_result none;
        none = '{RK_STATUS, '0, '0, '0, 1'b0, 1'b0};
        for (int n = 0; n < count; n++) begin
            build_item(ev);
            offer_item(ev, 1'b0, none);
            // now and then let the block run dry mid-phase
            if ($urandom_range(0, 39) == 0) drain_all();
        end
        drain_all();
    endtask

    task automatic add_row(input t_kind kind, input logic [31:0] now_ms,
                           input logic [31:0] ack_seq, input logic [31:0] ack_mask,
                           input logic [15:0] pay_len, input bit typed, input t_rkind rk,
                           input logic [31:0] seq, input int slot, input int pend,
                           input logic link);
        t_row row;
        row.ev    = '{kind, now_ms, ack_seq, ack_mask, pay_len};
        row.typed = typed;
        row.want  = '{rk, seq, slot[SLOT_W-1:0], pend[CNT_W-1:0], link, 1'b1};
        dir_rows.push_back(row);
    endtask

    // Receiver: random gaps, plus one long hold-off on request
    initial begin : rx_side
        int idle_left;
        idle_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                idle_left   = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else if (idle_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
                idle_left = gap_len();
            end
            if (idle_left > 0) begin
                i_m_axis_tready = 1'b0;
                idle_left--;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // Result checker: compare every accepted result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.rkind   = t_rkind'(o_m_axis_tuser);
            got.seq     = o_m_axis_tdata[31:0];
            got.slot    = o_m_axis_tdata[36:32];
            got.pend    = o_m_axis_tdata[42:37];
            got.link    = o_m_axis_tdata[43];
            got.is_last = o_m_axis_tlast;
            if (due_results.size() == 0) begin
                $error("unexpected result: result_kind %0d sequence_out %0d",
                       o_m_axis_tuser, got.seq);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (got.rkind !== want.rkind) begin
                    $error("result_kind: expected %0d, got %0d", want.rkind, o_m_axis_tuser);
                    fail_count++;
                end
                if (got.seq !== want.seq) begin
                    $error("sequence_out: expected %0d, got %0d", want.seq, got.seq);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot_out: expected %0d, got %0d", want.slot, got.slot);
                    fail_count++;
                end
                if (got.pend !== want.pend) begin
                    $error("pending_out: expected %0d, got %0d", want.pend, got.pend);
                    fail_count++;
                end
                if (got.link !== want.link) begin
                    $error("link_up: expected %0d, got %0d", want.link, got.link);
                    fail_count++;
                end
                if (got.is_last !== want.is_last) begin
                    $error("last: expected %0d, got %0d", want.is_last, got.is_last);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        t_event  ev;
        t_result none;
        none = '{RK_STATUS, '0, '0, '0, 1'b0, 1'b0};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table at reset defaults: interval 100, max resends 20, length 1184
        // rejects and status while the link is down, empty ring, all-ones fields
        add_row(KIND_SEND, 32'd0, 32'd0, 32'd0, 16'd0, 1, RK_NOCONN, 0, 0, 0, 1'b0);
        add_row(KIND_TICK, '1, '1, '1, '1, 1, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_ACK, '1, '1, '1, '1, 1, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_CONN, 32'd0, 32'd0, 32'd0, 16'd0, 1, RK_STATUS, 0, 0, 0, 1'b1);
        // length one over the limit, then exactly at it
        add_row(KIND_SEND, 32'd0, 32'd0, 32'd0, 16'd1185, 1, RK_LONG, 0, 0, 0, 1'b1);
        add_row(KIND_SEND, 32'd0, 32'd0, 32'd0, 16'd1184, 1, RK_SENT, 0, 0, 1, 1'b1);
        add_row(KIND_SEND, 32'hFFFF_FFF0, 32'd0, 32'd0, 16'd0, 1, RK_SENT, 1, 1, 2, 1'b1);
        add_row(KIND_SEND, 32'd0, 32'd0, 32'd0, 16'hFFFF, 1, RK_LONG, 0, 0, 2, 1'b1);
        // age across the time wrap, then both entries due
        add_row(KIND_TICK, 32'd99, 32'd0, 32'd0, 16'd0, 0, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_TICK, 32'd250, 32'd0, 32'd0, 16'd0, 0, RK_STATUS, 0, 0, 0, 1'b0);
        // ack plus mask bit zero clears both
        add_row(KIND_ACK, 32'd250, 32'd1, 32'd1, 16'd0, 1, RK_STATUS, 0, 0, 0, 1'b1);
        add_row(KIND_SEND, 32'd300, 32'd0, 32'd0, 16'd10, 0, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_SEND, 32'd300, 32'd0, 32'd0, 16'd10, 0, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_SEND, 32'd300, 32'd0, 32'd0, 16'd10, 0, RK_STATUS, 0, 0, 0, 1'b0);
        // ack the newest only: the head stays, nothing pops
        add_row(KIND_ACK, 32'd300, 32'd4, 32'd0, 16'd0, 1, RK_STATUS, 0, 0, 3, 1'b1);
        add_row(KIND_ACK, 32'd300, 32'd3, 32'd1, 16'd0, 1, RK_STATUS, 0, 0, 0, 1'b1);
        // top mask bit reaches 32 back; one further is out of reach
        add_row(KIND_SEND, 32'd400, 32'd0, 32'd0, 16'd1, 0, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_ACK, 32'd400, 32'd37, 32'h8000_0000, 16'd0, 1, RK_STATUS, 0, 0, 0, 1'b1);
        add_row(KIND_SEND, 32'd500, 32'd0, 32'd0, 16'd1, 0, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_ACK, 32'd500, 32'd39, '1, 16'd0, 1, RK_STATUS, 0, 0, 1, 1'b1);
        // ack behind the entry wraps to a huge distance: no effect
        add_row(KIND_ACK, 32'd500, 32'd5, '1, 16'd0, 1, RK_STATUS, 0, 0, 1, 1'b1);
        // reconnect with an entry pending restarts numbering at zero
        add_row(KIND_CONN, 32'd500, 32'd0, 32'd0, 16'd0, 1, RK_STATUS, 0, 0, 1, 1'b1);
        add_row(KIND_SEND, 32'd600, 32'd0, 32'd0, 16'd2, 0, RK_STATUS, 0, 0, 0, 1'b0);
        add_row(KIND_ACK, 32'd600, 32'd6, 32'd0, 16'd0, 1, RK_STATUS, 0, 0, 1, 1'b1);
        add_row(KIND_ACK, 32'd600, 32'd0, 32'd0, 16'd0, 1, RK_STATUS, 0, 0, 0, 1'b1);

        foreach (dir_rows[r]) offer_item(dir_rows[r].ev, dir_rows[r].typed, dir_rows[r].want);
        drain_all();
        t_now = 32'd1000;

        // Mid-range settings, both sides idle at random
        write_reg(CFG_RESEND_INTERVAL, 16'd40);
        write_reg(CFG_MAX_RESENDS, 16'd4);
        write_reg(CFG_MAX_PAYLOAD, 16'd1500);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(80);

        // Low extremes: a tick resends every unacked entry aged 1 or more, the second resend drops the link,
        // only empty payloads fit; upper data bits of the 8-bit register are junk
        write_reg(CFG_RESEND_INTERVAL, 16'd1);
        write_reg(CFG_MAX_RESENDS, 16'hFF01);
        write_reg(CFG_MAX_PAYLOAD, 16'd0);
        write_reg(CFG_SPARE, 16'hA5A5);
        tx_idle_on = 1'b0;
        run_random(60);

        // High extremes: fill the ring while the receiver holds off, so the
        // block stalls its input, then overflow it at least twice
        write_reg(CFG_RESEND_INTERVAL, 16'hFFFF);
        write_reg(CFG_MAX_RESENDS, 16'd255);
        write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
        rx_idle_on = 1'b0;
        ev = '{KIND_CONN, t_now, 32'd0, 32'd0, 16'd0};
        offer_item(ev, 1'b0, none);
        rx_hold_req = 1'b1;
        for (int n = 0; n < WINDOW + 2; n++) begin
            ev = '{KIND_SEND, t_now, $urandom, $urandom, 16'($urandom)};
            offer_item(ev, 1'b0, none);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(40);

        // Random settings
        write_reg(CFG_RESEND_INTERVAL, 16'($urandom_range(1, 400)));
        write_reg(CFG_MAX_RESENDS, 16'($urandom_range(1, 8)));
        write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(0, 2000)));
        write_reg(CFG_SPARE, 16'($urandom));
        run_random(90);

        // Everything is owed back by now; watch for stray results
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
